// File: design/rescan_byte_window_filter_defines.svh
// Assertion macros used by the checker file of the window filter.
`ifndef RESCAN_BYTE_WINDOW_FILTER_DEFINES_SVH
`define RESCAN_BYTE_WINDOW_FILTER_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define RBWF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same, on the block's own clock and reset names.
`define RBWF_ASSERT_CLK(lbl, prop, msg) \
  `RBWF_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/rbwf_pkg.sv
package rbwf_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 4096;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int FILL_W      = OFF_W + 1;
  localparam int MAX_PATTERN = 16;
  localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = 5;
  localparam int PAT_HALF_W  = 64;
  localparam int WOFF_W      = 12;
  localparam int CNT_W       = 13;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    SCAN_ANY   = 2'd0,
    SCAN_EQUAL = 2'd1,
    SCAN_RISE  = 2'd2,
    SCAN_FALL  = 2'd3
  } scan_mode_e;

  typedef enum logic [1:0] {
    CFG_SCAN_MODE      = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_PATTERN_LOW    = 2'd2,
    CFG_PATTERN_HIGH   = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [WOFF_W-1:0] window_offset;
    logic              still_candidate;
    logic [CNT_W-1:0]  match_count;
    logic              last;
  } out_item_t;

  // Per-cell compare of the current byte against the snapshot byte
  typedef struct packed {
    logic eq_prev;
    logic gt_prev;
  } cell_flags_t;

  // Decision context for the window under test
  typedef struct packed {
    logic complete;
    logic cand;
  } judge_req_t;

  // Pick pattern byte idx out of {high, low}
  function automatic logic [7:0] pat_byte(input logic [2*PAT_HALF_W-1:0] pat,
                                          input logic [PIDX_W-1:0]       idx);
    return pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: design/rescan_byte_window_filter.sv
// A byte's first result is registered after the first and second stages. Throughput: one
// byte per cycle inside a block unless stalled; the window cell chain shifts as each byte
// leaves the first stage. End of block: up to the clamped window length of results leave,
// one per cycle unless stalled, and the next block's first byte is taken once the block's
// last result sits in the output register. Reset: control state clears at once; snapshot
// and candidate memories read as zero from a fill count up, so no clearing pass is needed.
module rescan_byte_window_filter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rbwf_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rbwf_pkg::out_item_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i
);
  import rbwf_pkg::*;

  // Configuration registers
  scan_mode_e              scan_mode_q;
  logic [LEN_W-1:0]        pattern_length_q;
  logic [PAT_HALF_W-1:0]   pattern_low_q;
  logic [PAT_HALF_W-1:0]   pattern_high_q;

  // Block control
  logic [OFF_W-1:0]        off_q;
  scan_mode_e              held_mode_q;
  logic [LEN_W-1:0]        held_len_q;
  logic                    busy_q;
  logic [FILL_W-1:0]       fill_q;
  logic [CNT_W-1:0]        cnt_q;

  // First stage: byte and snapshot read
  logic                    s1_valid_q;
  logic [7:0]              s1_byte_q;
  logic [OFF_W-1:0]        s1_c_q;
  logic                    s1_end_q;
  logic                    s1_snap_ok_q;
  logic [7:0]              snap_rd_q;

  // Second stage: window decision and tail sequencing
  logic                    s2_valid_q;
  logic [OFF_W-1:0]        s2_c_q;
  logic                    s2_end_q;
  logic                    s2_complete_q;
  logic [OFF_W-1:0]        emit_off_q;
  logic                    first_q;
  logic                    cand_rd_q;
  logic                    cand_ok_q;

  // Output register
  logic                    out_valid_q;
  out_item_t               out_q;

  // Memories
  logic [7:0]              snap_mem [BLOCK_BYTES];
  logic                    cand_mem [BLOCK_BYTES];

  logic                    cfg_accept;
  logic                    in_accept;
  logic                    end_eff;
  logic [LEN_W-1:0]        len_clamp;
  logic                    out_free;
  logic                    s2_has_emit;
  logic                    s2_last;
  logic                    s2_free;
  logic                    s1_ready;
  logic                    s1_move;
  logic                    out_load;
  logic                    blk_done;
  logic [OFF_W:0]          c_plus;
  logic                    complete;
  logic [OFF_W:0]          off_full;
  logic [OFF_W-1:0]        off_calc;
  logic [FILL_W-1:0]       fill_d;
  logic [CNT_W-1:0]        cnt_d;
  logic                    keep;
  logic [7:0]              prev_in;
  judge_req_t              req;

  logic [MAX_PATTERN:0][7:0] feed_cur;
  logic [MAX_PATTERN:0][7:0] feed_prev;
  cell_flags_t [MAX_PATTERN-1:0] flags_w;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i & cfg_ready_o;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q      <= SCAN_ANY;
      pattern_length_q <= LEN_W'(1);
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SCAN_MODE:      scan_mode_q      <= scan_mode_e'(cfg_data_i[1:0]);
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
      endcase
    end
  end

  // Handshake and stage flow
  always_comb begin
    out_free    = ~out_valid_q | out_ready_i;
    s2_has_emit = s2_complete_q | s2_end_q;
    s2_last     = ~s2_end_q | (emit_off_q == s2_c_q);
    s2_free     = ~s2_valid_q | ~s2_has_emit | (out_free & s2_last);
    out_load    = s2_valid_q & s2_has_emit & out_free;
    blk_done    = out_load & s2_end_q & s2_last;
    s1_ready    = ~s1_valid_q | s2_free;
    s1_move     = s1_valid_q & s2_free;
    in_ready_o  = s1_ready & ~busy_q;
    in_accept   = in_valid_i & in_ready_o;
    end_eff     = in_data_i.end_of_block | (off_q == OFF_W'(BLOCK_BYTES - 1));
  end

  // Clamp the window length sampled at offset zero
  always_comb begin
    if (pattern_length_q == '0) begin
      len_clamp = LEN_W'(1);
    end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
      len_clamp = LEN_W'(MAX_PATTERN);
    end else begin
      len_clamp = pattern_length_q;
    end
  end

  // Offset of the window completed by the byte leaving the first stage
  always_comb begin
    c_plus   = {1'b0, s1_c_q} + 1'b1;
    complete = (c_plus >= (OFF_W + 1)'(held_len_q));
    off_full = c_plus - (OFF_W + 1)'(held_len_q);
    off_calc = off_full[OFF_W-1:0];
    prev_in  = s1_snap_ok_q ? snap_rd_q : 8'h00;
  end

  // Snapshot and candidate memories
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      snap_rd_q        <= snap_mem[off_q];
      snap_mem[off_q]  <= in_data_i.data_byte;
    end
    if (s1_move) begin
      cand_rd_q <= cand_mem[off_calc];
    end
    if (out_load) begin
      cand_mem[emit_off_q] <= keep;
    end
  end

  // Block control: offset, latched mode and length, drain hold, fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      held_mode_q <= SCAN_ANY;
      held_len_q  <= LEN_W'(1);
      busy_q      <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (in_accept) begin
        off_q <= end_eff ? '0 : off_q + 1'b1;
        if (off_q == '0) begin
          held_mode_q <= scan_mode_q;
          held_len_q  <= len_clamp;
        end
      end
      if (in_accept && end_eff) begin
        busy_q <= 1'b1;
      end else if (blk_done) begin
        busy_q <= 1'b0;
      end
      if (blk_done) begin
        fill_q <= fill_d;
      end
    end
  end

  assign fill_d = (({1'b0, s2_c_q} + 1'b1) > fill_q) ? ({1'b0, s2_c_q} + 1'b1) : fill_q;

  // First stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_byte_q    <= '0;
      s1_c_q       <= '0;
      s1_end_q     <= 1'b0;
      s1_snap_ok_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q   <= 1'b1;
        s1_byte_q    <= in_data_i.data_byte;
        s1_c_q       <= off_q;
        s1_end_q     <= end_eff;
        s1_snap_ok_q <= ({1'b0, off_q} < fill_q);
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Second stage: load a window, then step through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q    <= 1'b0;
      s2_c_q        <= '0;
      s2_end_q      <= 1'b0;
      s2_complete_q <= 1'b0;
      emit_off_q    <= '0;
      first_q       <= 1'b0;
      cand_ok_q     <= 1'b0;
    end else begin
      if (s1_move) begin
        s2_valid_q    <= 1'b1;
        s2_c_q        <= s1_c_q;
        s2_end_q      <= s1_end_q;
        s2_complete_q <= complete;
        emit_off_q    <= complete ? off_calc : '0;
        first_q       <= 1'b1;
        cand_ok_q     <= ({1'b0, off_calc} < fill_q);
      end else begin
        if (s2_free) begin
          s2_valid_q <= 1'b0;
        end
        if (out_load) begin
          first_q <= 1'b0;
          if (!s2_last) begin
            emit_off_q <= emit_off_q + 1'b1;
          end
        end
      end
    end
  end

  // Window cell chain
  assign feed_cur[0]  = s1_byte_q;
  assign feed_prev[0] = prev_in;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    rbwf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_move),
      .cur_i   (feed_cur[k]),
      .prev_i  (feed_prev[k]),
      .cur_o   (feed_cur[k+1]),
      .prev_o  (feed_prev[k+1]),
      .flags_o (flags_w[k])
    );
  end

  assign req.complete = s2_complete_q & first_q;
  assign req.cand     = cand_ok_q & cand_rd_q;

  rbwf_judge u_judge (
    .mode_i    (held_mode_q),
    .len_i     (held_len_q),
    .pattern_i ({pattern_high_q, pattern_low_q}),
    .cur_i     (feed_cur[MAX_PATTERN:1]),
    .flags_i   (flags_w),
    .req_i     (req),
    .keep_o    (keep)
  );

  // Count survivors, saturating
  assign cnt_d = (keep && (cnt_q != COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_move && (s1_c_q == '0)) begin
      cnt_q <= '0;
    end else if (out_load) begin
      cnt_q <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.window_offset   <= WOFF_W'(emit_off_q);
      out_q.still_candidate <= keep;
      out_q.match_count     <= (s2_end_q && s2_last) ? cnt_d : '0;
      out_q.last            <= s2_end_q & s2_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/rbwf_cell.sv
module rbwf_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [7:0]           cur_i,
  input  logic [7:0]           prev_i,
  output logic [7:0]           cur_o,
  output logic [7:0]           prev_o,
  output rbwf_pkg::cell_flags_t flags_o
);
  import rbwf_pkg::*;

  logic [7:0] cur_q;
  logic [7:0] prev_q;

  // Take the neighbor's byte pair on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= '0;
    end else if (shift_i) begin
      cur_q  <= cur_i;
      prev_q <= prev_i;
    end
  end

  // Compare this position against the previous scan
  always_comb begin
    flags_o.eq_prev = (cur_q == prev_q);
    flags_o.gt_prev = (cur_q > prev_q);
  end

  assign cur_o  = cur_q;
  assign prev_o = prev_q;

endmodule

// File: design/rbwf_judge.sv
module rbwf_judge (
  input  rbwf_pkg::scan_mode_e                                mode_i,
  input  logic [rbwf_pkg::LEN_W-1:0]                          len_i,
  input  logic [2*rbwf_pkg::PAT_HALF_W-1:0]                   pattern_i,
  input  logic [rbwf_pkg::MAX_PATTERN-1:0][7:0]               cur_i,
  input  rbwf_pkg::cell_flags_t [rbwf_pkg::MAX_PATTERN-1:0]   flags_i,
  input  rbwf_pkg::judge_req_t                                req_i,
  output logic                                                keep_o
);
  import rbwf_pkg::*;

  logic [PIDX_W-1:0] idx_top;
  logic              eq_all;
  logic              found;
  logic              gt_sel;
  logic              first_eq;
  logic              passes;

  // Cell k holds window byte len-1-k; the oldest byte sits in cell len-1
  always_comb begin
    idx_top = PIDX_W'(len_i - 1'b1);
    eq_all  = 1'b1;
    found   = 1'b0;
    gt_sel  = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < int'(len_i)) begin
        if (cur_i[k] != pat_byte(pattern_i, PIDX_W'(idx_top - PIDX_W'(k)))) begin
          eq_all = 1'b0;
        end
      end
      // Highest differing cell below the first byte is the earliest difference
      if ((k < int'(len_i) - 1) && !flags_i[k].eq_prev) begin
        found  = 1'b1;
        gt_sel = flags_i[k].gt_prev;
      end
    end
    first_eq = flags_i[idx_top].eq_prev;
  end

  // Apply the condition of the latched mode
  always_comb begin
    unique case (mode_i)
      SCAN_ANY:   passes = 1'b1;
      SCAN_EQUAL: passes = eq_all;
      SCAN_RISE:  passes = first_eq & found & gt_sel;
      SCAN_FALL:  passes = first_eq & found & ~gt_sel;
    endcase
    keep_o = (mode_i == SCAN_ANY) | (req_i.complete & req_i.cand & passes);
  end

endmodule

// File: design/rbwf_checker.sv
`include "rescan_byte_window_filter_defines.svh"

module rbwf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rbwf_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rbwf_pkg::out_item_t out_data_o
);
  import rbwf_pkg::*;

  // Hold a stalled result
  `RBWF_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Only the last result of a block carries a count
  `RBWF_ASSERT_CLK(a_count_last, out_valid_o && !out_data_o.last |-> out_data_o.match_count == '0, "count on a non-last result")

  // Stop taking bytes after a byte flagged as the end of its block
  `RBWF_ASSERT_CLK(a_end_drain, in_valid_i && in_ready_o && in_data_i.end_of_block |=> !in_ready_o, "byte taken during block drain")

endmodule

bind rescan_byte_window_filter rbwf_checker u_rbwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/tb.sv
import rbwf_pkg::*;

// Predicts the filter decision for every offset and checks the results in order.
class survivor_scoreboard;
  logic [7:0]              snapshot [BLOCK_BYTES];
  bit                      candidate [BLOCK_BYTES];
  logic [7:0]              cur_win [MAX_PATTERN];
  logic [7:0]              old_win [MAX_PATTERN];
  int unsigned             next_off;
  int unsigned             survivors;
  int unsigned             held_len;
  scan_mode_e              held_mode;
  scan_mode_e              mode_reg;
  logic [LEN_W-1:0]        length_reg;
  logic [2*PAT_HALF_W-1:0] pattern;
  out_item_t               decisions_q [$];
  int                      errors;

  function new();
    foreach (snapshot[i]) begin
      snapshot[i]  = '0;
      candidate[i] = 1'b0;
    end
    foreach (cur_win[i]) begin
      cur_win[i] = '0;
      old_win[i] = '0;
    end
    next_off   = 0;
    survivors  = 0;
    held_len   = 1;
    held_mode  = SCAN_ANY;
    mode_reg   = SCAN_ANY;
    length_reg = 1;
    pattern    = '0;
    errors     = 0;
  endfunction

  // Mirror one register transaction
  function void apply_register(cfg_index_e idx, logic [63:0] value);
    case (idx)
      CFG_SCAN_MODE:      mode_reg = scan_mode_e'(value[1:0]);
      CFG_PATTERN_LENGTH: length_reg = value[LEN_W-1:0];
      CFG_PATTERN_LOW:    pattern[PAT_HALF_W-1:0] = value;
      CFG_PATTERN_HIGH:   pattern[2*PAT_HALF_W-1:PAT_HALF_W] = value;
      default: ;
    endcase
  endfunction

  // Compare the completed window; the oldest byte sits at index len-1
  function bit window_holds(int unsigned len);
    logic [7:0] now_b;
    logic [7:0] was_b;
    if (held_mode == SCAN_EQUAL) begin
      for (int i = 0; i < len; i++)
        if (cur_win[len-1-i] != pattern[8*i +: 8]) return 1'b0;
      return 1'b1;
    end
    if (cur_win[len-1] != old_win[len-1]) return 1'b0;
    for (int i = 1; i < len; i++) begin
      now_b = cur_win[len-1-i];
      was_b = old_win[len-1-i];
      if (now_b != was_b)
        return (held_mode == SCAN_RISE) ? (now_b > was_b) : (now_b < was_b);
    end
    return 1'b0;
  endfunction

  // Decide one offset, update its candidate bit and the survivor count
  function bit decide(int unsigned off, bit complete);
    bit keep;
    if (held_mode == SCAN_ANY) keep = 1'b1;
    else if (!complete || !candidate[off]) keep = 1'b0;
    else keep = window_holds(held_len);
    candidate[off] = keep;
    if (keep && survivors < COUNT_MAX) survivors++;
    return keep;
  endfunction

  function void queue_decision(int unsigned off, bit keep);
    out_item_t res;
    res.window_offset   = WOFF_W'(off);
    res.still_candidate = keep;
    res.match_count     = '0;
    res.last            = 1'b0;
    decisions_q.push_back(res);
  endfunction

  // Note one accepted byte and queue the decisions it causes
  function void take_byte(in_item_t item);
    int unsigned c;
    int unsigned len;
    int unsigned first;
    bit          closing;
    out_item_t   res;
    c       = next_off;
    closing = item.end_of_block || (c >= BLOCK_BYTES - 1);
    if (c == 0) begin
      held_mode = mode_reg;
      if (length_reg == 0) held_len = 1;
      else if (length_reg > MAX_PATTERN) held_len = MAX_PATTERN;
      else held_len = length_reg;
      survivors = 0;
    end
    len = held_len;
    for (int k = MAX_PATTERN - 1; k > 0; k--) begin
      cur_win[k] = cur_win[k-1];
      old_win[k] = old_win[k-1];
    end
    cur_win[0]  = item.data_byte;
    old_win[0]  = snapshot[c];
    snapshot[c] = item.data_byte;
    first = 0;
    if (c + 1 >= len) begin
      queue_decision(c + 1 - len, decide(c + 1 - len, 1'b1));
      first = c + 2 - len;
    end
    if (closing) begin
      // Windows that run past the end are decided now, in offset order
      for (int unsigned o = first; o <= c; o++) queue_decision(o, decide(o, 1'b0));
      res = decisions_q.pop_back();
      res.match_count = CNT_W'(survivors);
      res.last        = 1'b1;
      decisions_q.push_back(res);
      next_off = 0;
    end else begin
      next_off = c + 1;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (decisions_q.size() == 0) begin
      report($sformatf("result for offset %0d with nothing expected", got.window_offset));
      return;
    end
    want = decisions_q.pop_front();
    if (got.window_offset !== want.window_offset)
      report($sformatf("window_offset got %0d, want %0d", got.window_offset,
                       want.window_offset));
    if (got.still_candidate !== want.still_candidate)
      report($sformatf("offset %0d: still_candidate got %b, want %b", want.window_offset,
                       got.still_candidate, want.still_candidate));
    if (got.match_count !== want.match_count)
      report($sformatf("offset %0d: match_count got %0d, want %0d", want.window_offset,
                       got.match_count, want.match_count));
    if (got.last !== want.last)
      report($sformatf("offset %0d: last got %b, want %b", want.window_offset,
                       got.last, want.last));
  endtask

  task flush_check();
    if (decisions_q.size() != 0)
      report($sformatf("%0d results never arrived", decisions_q.size()));
  endtask
endclass

module tb;
  typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} idle_phase_e;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned RANDOM_BYTES = 320;
  localparam int unsigned PHASE_BYTES  = RANDOM_BYTES / 4;
  localparam int unsigned LONG_BYTES   = 64;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;

  survivor_scoreboard sb = new();

  logic [7:0]  image [BLOCK_BYTES];
  int unsigned send_idle   = 0;
  int unsigned recv_stall  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned quiet_ticks = 0;

  rescan_byte_window_filter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall);

  // Watch every channel, predict and check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.apply_register(cfg_index_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) sb.take_byte(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i))
        quiet_ticks <= 0;
      else
        quiet_ticks <= quiet_ticks + 1;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    wait (rst_ni);
    while (quiet_ticks < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic set_phase(idle_phase_e ph);
    case (ph)
      PH_STEADY:      begin send_idle = 0;  recv_stall = 0;  end
      PH_SEND_GAPS:   begin send_idle = 55; recv_stall = 0;  end
      PH_RECV_STALLS: begin send_idle = 0;  recv_stall = 55; end
      default:        begin send_idle = 6;  recv_stall = 6;  end
    endcase
  endtask

  // Offer one byte, with an optional idle gap first, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input bit eob);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_block: eob};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic scan_image(input int unsigned n, input bit eob_last);
    for (int unsigned i = 0; i < n; i++) send_byte(image[i], eob_last && (i == n - 1));
  endtask

  // Drop valid, wait for every expected result, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.decisions_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic set_register(input cfg_index_e idx, input logic [63:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pattern_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly rescan the same block; now and then cut it short or run over
  function automatic int unsigned scan_length(int unsigned n);
    if ($urandom_range(7) == 0) return $urandom_range(1, n + 3);
    return n;
  endfunction

  // Change some bytes of the block between scans
  task automatic nudge(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(2))
          0:       image[i] = image[i] + 8'($urandom_range(1, 3));
          1:       image[i] = image[i] - 8'($urandom_range(1, 3));
          default: image[i] = random_byte();
        endcase
      end
    end
  endtask

  task automatic directed_checks();
    // Reset settings: unconditional, one-byte windows
    image[0] = 8'hff;
    scan_image(1, 1'b1);
    // Zero length acts as one; equals against an all-ones pattern
    set_register(CFG_SCAN_MODE, 64'(SCAN_EQUAL));
    set_register(CFG_PATTERN_LENGTH, 64'd0);
    set_register(CFG_PATTERN_LOW, '1);
    image[0] = 8'hff;
    image[1] = 8'h00;
    scan_image(2, 1'b1);
    // Overlong length acts as the maximum; unconditional windows past the end survive
    set_register(CFG_SCAN_MODE, 64'(SCAN_ANY));
    set_register(CFG_PATTERN_LENGTH, 64'd31);
    image[0] = 8'h00;
    image[1] = 8'hff;
    image[2] = 8'h7f;
    scan_image(3, 1'b1);
    // Full-width pattern can never complete inside three bytes
    set_register(CFG_SCAN_MODE, 64'(SCAN_EQUAL));
    set_register(CFG_PATTERN_HIGH, '1);
    set_register(CFG_PATTERN_LENGTH, 64'(MAX_PATTERN));
    scan_image(3, 1'b1);
    // Two-byte windows: seed, then rise, fall and no change
    set_register(CFG_SCAN_MODE, 64'(SCAN_ANY));
    set_register(CFG_PATTERN_LENGTH, 64'd2);
    image[0] = 8'd10;
    image[1] = 8'd20;
    scan_image(2, 1'b1);
    set_register(CFG_SCAN_MODE, 64'(SCAN_RISE));
    image[1] = 8'd21;
    scan_image(2, 1'b1);
    set_register(CFG_SCAN_MODE, 64'(SCAN_FALL));
    image[1] = 8'd20;
    scan_image(2, 1'b1);
    set_register(CFG_SCAN_MODE, 64'(SCAN_RISE));
    scan_image(2, 1'b1);
  endtask

  // Longer block seeded unconditionally, then rescanned for decreases
  task automatic long_block_checks();
    set_register(CFG_SCAN_MODE, 64'(SCAN_ANY));
    set_register(CFG_PATTERN_LENGTH, 64'($urandom_range(1, MAX_PATTERN)));
    for (int unsigned i = 0; i < LONG_BYTES; i++) image[i] = random_byte();
    scan_image(LONG_BYTES, 1'b1);
    nudge(LONG_BYTES);
    set_register(CFG_SCAN_MODE, 64'(SCAN_FALL));
    scan_image(LONG_BYTES, 1'b1);
  endtask

  // Seed a small block, optionally filter on a pattern, then follow its changes
  task automatic random_round();
    int unsigned             n;
    int unsigned             len;
    int unsigned             eff;
    int unsigned             o;
    logic [2*PAT_HALF_W-1:0] pat;
    n = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 28);
    case ($urandom_range(9))
      0:       len = 0;
      1:       len = $urandom_range(MAX_PATTERN + 1, 31);
      2:       len = MAX_PATTERN;
      default: len = $urandom_range(1, 6);
    endcase
    eff = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : len;
    for (int unsigned i = 0; i < n; i++) image[i] = random_byte();
    set_register(CFG_SCAN_MODE, 64'(SCAN_ANY));
    set_register(CFG_PATTERN_LENGTH, 64'(len));
    scan_image(n, 1'b1);
    if ($urandom_range(9) < 6) begin
      pat = {pattern_word(), pattern_word()};
      set_register(CFG_SCAN_MODE, 64'(SCAN_EQUAL));
      set_register(CFG_PATTERN_LOW, pat[PAT_HALF_W-1:0]);
      set_register(CFG_PATTERN_HIGH, pat[2*PAT_HALF_W-1:PAT_HALF_W]);
      // Plant the pattern at a few offsets
      repeat ($urandom_range(1, 3)) begin
        o = $urandom_range(0, n - 1);
        for (int unsigned i = 0; i < eff && o + i < n; i++) image[o+i] = pat[8*i +: 8];
      end
      scan_image(scan_length(n), 1'b1);
    end
    repeat ($urandom_range(2, 3)) begin
      nudge(n);
      if ($urandom_range(7) == 0)
        set_register(CFG_PATTERN_LENGTH, 64'($urandom_range(0, 31)));
      set_register(CFG_SCAN_MODE,
                   64'($urandom_range(1) ? SCAN_RISE : SCAN_FALL));
      scan_image(scan_length(n), 1'b1);
    end
  endtask

  initial begin
    int unsigned rand_start;
    set_phase(PH_STEADY);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    set_phase(PH_BOTH);
    long_block_checks();
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      set_phase(idle_phase_e'(((bytes_sent - rand_start) / PHASE_BYTES) % 4));
      random_round();
    end
    settle();
    sb.flush_check();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/rbwf_pkg.sv
design/rbwf_cell.sv
design/rbwf_judge.sv
design/rescan_byte_window_filter.sv
design/rbwf_checker.sv
tb/tb.sv
